[hdl/mnt_pkg.sv]
// ----------------------------------------------------------------------------
// mnt_pkg
// Shared types and constants for the neighbour table.
// ----------------------------------------------------------------------------
package mnt_pkg;

    localparam logic [1:0] OP_BEACON = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_UNUSED = 2'd0;
    localparam logic [1:0] ST_VALID  = 2'd1;
    localparam logic [1:0] ST_LOST   = 2'd2;

    localparam logic [1:0] REG_RSSI_OFFSET = 2'd0;
    localparam logic [1:0] REG_LOST_AFTER  = 2'd1;
    localparam logic [1:0] REG_DROP_AFTER  = 2'd2;

    localparam logic [16:0] DAY_SECONDS = 17'd86400;
    localparam logic [31:0] SEQ_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0] VPN_ANY = 16'hFFFF;

    // Classified command handed from the front end to the table engine.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] src_call;
        logic [15:0] src_vpn;
        logic [31:0] seq_num;
        logic [3:0]  hops;
        logic [8:0]  rssi;
        logic [7:0]  cap_flags;
        logic [7:0]  tx_power;
    } t_cmd;

endpackage

[hdl/mnt_front.sv]
// ----------------------------------------------------------------------------
// mnt_front
// Accepts input transactions, converts RSSI and queues commands.
// ----------------------------------------------------------------------------
module mnt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_rssi_offset,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_opcode,
    input  logic [31:0]    i_src_call,
    input  logic [15:0]    i_src_vpn,
    input  logic [31:0]    i_seq_num,
    input  logic [3:0]     i_hops,
    input  logic [7:0]     i_rssi_raw,
    input  logic [7:0]     i_cap_flags,
    input  logic [7:0]     i_tx_power,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output mnt_pkg::t_cmd  o_cmd
);
    import mnt_pkg::*;

    // two-entry queue
    t_cmd       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd.opcode    = i_opcode;
        w_cmd.src_call  = i_src_call;
        w_cmd.src_vpn   = i_src_vpn;
        w_cmd.seq_num   = i_seq_num;
        w_cmd.hops      = i_hops;
        w_cmd.rssi      = {2'b00, i_rssi_raw[7:1]} - {1'b0, i_rssi_offset};
        w_cmd.cap_flags = i_cap_flags;
        w_cmd.tx_power  = i_tx_power;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

[hdl/mnt_engine.sv]
// ----------------------------------------------------------------------------
// mnt_engine
// Scans the table one slot at a time, updates or appends, ages on a tick.
// ----------------------------------------------------------------------------
module mnt_engine #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [16:0]   i_lost_after,
    input  logic [16:0]   i_drop_after,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  mnt_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_accepted,
    output logic          o_known,
    output logic [6:0]    o_entry_index,
    output logic [6:0]    o_entries_used,
    output logic          o_table_full
);
    import mnt_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [6:0] NONE = 7'(ENTRIES);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_RESULT} t_state;

    // one memory row per slot; rows at or above the fill count are never scanned
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] call;
        logic [15:0] vpn;
        logic [31:0] next_seq;
        logic [8:0]  rssi;
        logic [7:0]  power;
        logic [7:0]  caps;
        logic [16:0] heard;
        logic [3:0]  hops;
    } t_row;

    t_row        r_mem [ENTRIES];
    t_row        r_rd;
    t_state      r_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_idx;
    logic [16:0] r_now;
    logic        r_accepted, r_known, r_full;
    logic [6:0]  r_index;

    logic        w_match;
    logic [16:0] w_elapsed;
    logic [17:0] w_diff;
    logic [31:0] w_exp;
    logic [31:0] w_next;
    logic [IW-1:0] w_slot;
    logic        w_wr;
    logic [IW-1:0] w_wa;
    t_row        w_wd;

    assign w_slot      = r_idx[IW-1:0];
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_RESULT);
    assign o_accepted  = r_accepted;
    assign o_known     = r_known;
    assign o_entry_index  = r_index;
    assign o_entries_used = 7'(r_used);
    assign o_table_full   = r_full;

    always_comb begin
        w_match = (r_rd.call == r_cmd.src_call)
               && (r_cmd.src_vpn == VPN_ANY || r_rd.vpn == r_cmd.src_vpn)
               && (r_rd.status == ST_VALID);
        w_diff = {1'b0, r_now} - {1'b0, r_rd.heard};
        w_elapsed = w_diff[17] ? 17'(w_diff + {1'b0, DAY_SECONDS}) : w_diff[16:0];
        w_exp = (r_cmd.seq_num == SEQ_ALL_ONES) ? 32'd0 : r_rd.next_seq;
        w_next = (r_cmd.seq_num == SEQ_ALL_ONES) ? 32'd0 : r_cmd.seq_num + 32'd1;
    end

    // table write port: append, update of a matched row, or aging of a row
    always_comb begin
        w_wr = 1'b0;
        w_wa = w_slot;
        w_wd = r_rd;
        case (r_state)
            S_READ: begin
                if (r_idx >= r_used && r_cmd.opcode != OP_TICK
                        && r_used != CW'(ENTRIES)) begin
                    w_wr          = 1'b1;
                    w_wa          = r_used[IW-1:0];
                    w_wd.status   = ST_VALID;
                    w_wd.call     = r_cmd.src_call;
                    w_wd.vpn      = r_cmd.src_vpn;
                    w_wd.heard    = r_now;
                    w_wd.next_seq = w_next;
                    w_wd.rssi     = r_cmd.rssi;
                    w_wd.hops     = r_cmd.hops;
                    w_wd.caps     = (r_cmd.opcode == OP_BEACON) ? r_cmd.cap_flags : 8'd0;
                    w_wd.power    = (r_cmd.opcode == OP_BEACON) ? r_cmd.tx_power : 8'd0;
                end
            end
            S_CHECK: begin
                if (r_cmd.opcode == OP_TICK) begin
                    if (r_rd.status == ST_VALID && w_elapsed > i_lost_after) begin
                        w_wr        = 1'b1;
                        w_wd.status = ST_LOST;
                    end else if (r_rd.status == ST_LOST && w_elapsed > i_drop_after) begin
                        w_wr        = 1'b1;
                        w_wd.status = ST_UNUSED;
                    end
                end else if (w_match) begin
                    if (r_cmd.opcode == OP_BEACON) begin
                        if (r_rd.hops >= r_cmd.hops) begin
                            w_wr          = 1'b1;
                            w_wd.heard    = r_now;
                            w_wd.rssi     = r_cmd.rssi;
                            w_wd.next_seq = w_next;
                            w_wd.caps     = r_cmd.cap_flags;
                            w_wd.power    = r_cmd.tx_power;
                        end
                    end else begin
                        w_wr          = 1'b1;
                        w_wd.next_seq = (r_cmd.seq_num >= w_exp)
                                        ? r_cmd.seq_num + 32'd1 : w_exp;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && w_wr) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_now   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd      <= i_cmd;
                        r_idx      <= '0;
                        r_accepted <= 1'b0;
                        r_known    <= 1'b0;
                        r_full     <= 1'b0;
                        r_index    <= NONE;
                        if (i_cmd.opcode == OP_TICK) begin
                            r_now <= (r_now == DAY_SECONDS - 17'd1) ? '0 : r_now + 17'd1;
                        end
                        if (i_cmd.opcode == OP_NONE) begin
                            r_state <= S_RESULT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // row at r_idx is being read
                    if (r_idx >= r_used) begin
                        if (r_cmd.opcode == OP_TICK) begin
                            r_state <= S_RESULT;
                        end else begin
                            // append
                            if (r_cmd.opcode == OP_DATA) begin
                                r_accepted <= 1'b1;
                            end
                            if (r_used == CW'(ENTRIES)) begin
                                r_full <= 1'b1;
                            end else begin
                                r_index <= 7'(r_used);
                                r_used  <= r_used + CW'(1);
                            end
                            r_state <= S_RESULT;
                        end
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cmd.opcode != OP_TICK && w_match) begin
                        r_known <= 1'b1;
                        r_index <= 7'(r_idx);
                        r_state <= S_RESULT;
                        if (r_cmd.opcode == OP_DATA && r_cmd.seq_num >= w_exp) begin
                            r_accepted <= 1'b1;
                        end
                    end else begin
                        r_state <= S_READ;
                        r_idx   <= r_idx + CW'(1);
                    end
                end
                S_RESULT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/mesh_neighbour_table_top.sv]
// ----------------------------------------------------------------------------
// mesh_neighbour_table_top
// Table of heard mesh stations with sequence check and aging.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// input    | i_valid / o_ready   | opcode, src_call, src_vpn, seq_num, ...
// result   | o_valid / i_ready   | accepted, known, entry_index, ...
// config   | i_cfg_we            | i_cfg_index, i_cfg_data
// An item scans the used rows of the table memory one at a time, read then
// checked; the engine takes no new item until its result is accepted.
// Synchronous active-low reset clears fill count and time at once; rows at
// or above the fill count are never scanned, so the memory is not cleared.
// A two-deep queue takes up to two commands while a result stalls.
// ----------------------------------------------------------------------------
module mesh_neighbour_table_top #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_src_call,
    input  logic [15:0] i_src_vpn,
    input  logic [31:0] i_seq_num,
    input  logic [3:0]  i_hops,
    input  logic [7:0]  i_rssi_raw,
    input  logic [7:0]  i_cap_flags,
    input  logic [7:0]  i_tx_power,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic        o_known,
    output logic [6:0]  o_entry_index,
    output logic [6:0]  o_entries_used,
    output logic        o_table_full
);
    import mnt_pkg::*;

    logic [7:0]  r_rssi_offset;
    logic [16:0] r_lost_after, r_drop_after;
    logic        w_cmd_valid, w_cmd_ready;
    t_cmd        w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rssi_offset <= 8'd161;
            r_lost_after  <= 17'd1800;
            r_drop_after  <= 17'd3600;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RSSI_OFFSET: r_rssi_offset <= i_cfg_data[7:0];
                REG_LOST_AFTER:  r_lost_after  <= i_cfg_data;
                REG_DROP_AFTER:  r_drop_after  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mnt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rssi_offset(r_rssi_offset),
        .i_valid(i_valid), .o_ready(o_ready), .i_opcode(i_opcode),
        .i_src_call(i_src_call), .i_src_vpn(i_src_vpn), .i_seq_num(i_seq_num),
        .i_hops(i_hops), .i_rssi_raw(i_rssi_raw),
        .i_cap_flags(i_cap_flags), .i_tx_power(i_tx_power),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    mnt_engine #(.ENTRIES(ENTRIES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_lost_after(r_lost_after), .i_drop_after(r_drop_after),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid(o_valid), .i_ready(i_ready), .o_accepted(o_accepted),
        .o_known(o_known), .o_entry_index(o_entry_index),
        .o_entries_used(o_entries_used), .o_table_full(o_table_full)
    );

endmodule

[tb/mesh_neighbour_table_checker.sv]
// ----------------------------------------------------------------------------
// mesh_neighbour_table_checker
// Watches the input and result channels of the neighbour table, keeps its
// own copy of the station table and compares each result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mesh_neighbour_table_checker #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_src_call,
    input  logic [15:0] i_src_vpn,
    input  logic [31:0] i_seq_num,
    input  logic [3:0]  i_hops,
    input  logic [7:0]  i_rssi_raw,
    input  logic [7:0]  i_cap_flags,
    input  logic [7:0]  i_tx_power,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_accepted,
    input  logic        i_known,
    input  logic [6:0]  i_entry_index,
    input  logic [6:0]  i_entries_used,
    input  logic        i_table_full,
    output int          o_errors,
    output int          o_pending
);
    import mnt_pkg::*;

    typedef struct packed {
        logic       accepted;
        logic       known;
        logic [6:0] entry_index;
        logic [6:0] entries_used;
        logic       table_full;
    } t_verdict;

    t_verdict verdict_q[$];

    logic [16:0] lost_r, drop_r;
    logic [1:0]  st_m  [ENTRIES];
    logic [31:0] call_m[ENTRIES];
    logic [15:0] vpn_m [ENTRIES];
    logic [31:0] nseq_m[ENTRIES];
    logic [16:0] heard_m[ENTRIES];
    logic [3:0]  hops_m[ENTRIES];
    int          used_r;
    logic [16:0] now_r;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    function automatic logic [31:0] next_seq(input logic [31:0] s);
        return (s == SEQ_ALL_ONES) ? 32'd0 : s + 32'd1;
    endfunction

    task automatic predict_table(output t_verdict v);
        int hit;
        logic [16:0] gap;
        v = '0;
        v.entry_index = 7'(ENTRIES);
        hit = -1;
        if (i_opcode == OP_BEACON || i_opcode == OP_DATA) begin
            for (int i = 0; i < used_r; i++) begin
                if (hit < 0 && call_m[i] == i_src_call && st_m[i] == ST_VALID
                        && (i_src_vpn == VPN_ANY || vpn_m[i] == i_src_vpn))
                    hit = i;
            end
            if (hit >= 0) begin
                v.known = 1'b1;
                v.entry_index = 7'(hit);
                if (i_opcode == OP_BEACON) begin
                    if (hops_m[hit] >= i_hops) begin
                        heard_m[hit] = now_r;
                        nseq_m[hit] = next_seq(i_seq_num);
                        st_m[hit] = ST_VALID;
                    end
                end else begin
                    if (i_seq_num == SEQ_ALL_ONES) nseq_m[hit] = '0;
                    if (i_seq_num >= nseq_m[hit]) begin
                        nseq_m[hit] = i_seq_num + 32'd1;
                        v.accepted = 1'b1;
                    end
                end
            end else begin
                if (used_r < ENTRIES) begin
                    call_m[used_r] = i_src_call;
                    vpn_m[used_r] = i_src_vpn;
                    heard_m[used_r] = now_r;
                    nseq_m[used_r] = next_seq(i_seq_num);
                    hops_m[used_r] = i_hops;
                    st_m[used_r] = ST_VALID;
                    v.entry_index = 7'(used_r);
                    used_r++;
                end else begin
                    v.table_full = 1'b1;
                end
                if (i_opcode == OP_DATA) v.accepted = 1'b1;
            end
        end else if (i_opcode == OP_TICK) begin
            now_r = (now_r == DAY_SECONDS - 17'd1) ? 17'd0 : now_r + 17'd1;
            for (int i = 0; i < used_r; i++) begin
                gap = (now_r >= heard_m[i]) ? now_r - heard_m[i]
                                            : now_r + DAY_SECONDS - heard_m[i];
                if (st_m[i] == ST_VALID) begin
                    if (gap > lost_r) st_m[i] = ST_LOST;
                end else if (st_m[i] == ST_LOST) begin
                    if (gap > drop_r) st_m[i] = ST_UNUSED;
                end
            end
        end
        v.entries_used = 7'(used_r);
    endtask

    always @(posedge i_clk) begin
        t_verdict v, w;
        if (!i_rst_n) begin
            lost_r = 17'd1800;
            drop_r = 17'd3600;
            used_r = 0;
            now_r = '0;
            for (int i = 0; i < ENTRIES; i++) st_m[i] = ST_UNUSED;
            verdict_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LOST_AFTER: lost_r = i_cfg_data;
                    REG_DROP_AFTER: drop_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) begin
                predict_table(v);
                verdict_q.push_back(v);
            end
            if (i_res_valid && i_res_ready) begin
                if (verdict_q.size() == 0) begin
                    report("result with nothing expected", 16'd0, 16'd0);
                end else begin
                    w = verdict_q.pop_front();
                    if (i_accepted !== w.accepted)
                        report("accepted", 16'(i_accepted), 16'(w.accepted));
                    if (i_known !== w.known)
                        report("known", 16'(i_known), 16'(w.known));
                    if (i_entry_index !== w.entry_index)
                        report("entry_index", 16'(i_entry_index), 16'(w.entry_index));
                    if (i_entries_used !== w.entries_used)
                        report("entries_used", 16'(i_entries_used), 16'(w.entries_used));
                    if (i_table_full !== w.table_full)
                        report("table_full", 16'(i_table_full), 16'(w.table_full));
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

[tb/mesh_neighbour_table_top_test.sv]
// ----------------------------------------------------------------------------
// mesh_neighbour_table_top_test
// Drives beacons, data frames, ticks and no-op commands into the neighbour
// table with random stalls on both channels, rewrites the aging and signal
// registers between phases and leaves checking to the checker.
// ----------------------------------------------------------------------------
module mesh_neighbour_table_top_test;
    import mnt_pkg::*;

    localparam int ENTRIES = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = '0;
    logic [31:0] i_src_call = '0;
    logic [15:0] i_src_vpn = '0;
    logic [31:0] i_seq_num = '0;
    logic [3:0]  i_hops = '0;
    logic [7:0]  i_rssi_raw = '0;
    logic [7:0]  i_cap_flags = '0;
    logic [7:0]  i_tx_power = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_accepted, o_known, o_table_full;
    logic [6:0]  o_entry_index, o_entries_used;

    int errors, pending;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;
    logic [31:0] call_pool[8];
    logic [31:0] seq_pool[8];

    always #2 i_clk = ~i_clk;

    mesh_neighbour_table_top #(.ENTRIES(ENTRIES)) dut (.*);

    mesh_neighbour_table_checker #(.ENTRIES(ENTRIES)) checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_opcode, .i_src_call, .i_src_vpn,
        .i_seq_num, .i_hops, .i_rssi_raw, .i_cap_flags, .i_tx_power,
        .i_res_valid(o_valid), .i_res_ready(i_ready), .i_accepted(o_accepted),
        .i_known(o_known), .i_entry_index(o_entry_index),
        .i_entries_used(o_entries_used), .i_table_full(o_table_full),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // valid stays high into the next transaction unless the sender idles
    task automatic send_frame(input logic [1:0] op, input logic [31:0] call,
                              input logic [15:0] vpn, input logic [31:0] seq,
                              input logic [3:0] hops);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_src_call <= call;
        i_src_vpn <= vpn;
        i_seq_num <= seq;
        i_hops <= hops;
        i_rssi_raw <= 8'($urandom);
        i_cap_flags <= 8'($urandom);
        i_tx_power <= 8'($urandom);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2 * ENTRIES + 10) @(posedge i_clk);
    endtask

    // mostly a small pool of stations so lookups hit; rest is noise
    task automatic random_phase(input int count);
        int k, r;
        logic [1:0] op;
        logic [31:0] seq;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(7);
            r = $urandom_range(99);
            op = (r < 40) ? OP_BEACON : (r < 75) ? OP_DATA : (r < 97) ? OP_TICK : OP_NONE;
            case ($urandom_range(4))
                0: seq = $urandom;
                1: seq = SEQ_ALL_ONES;
                2: seq = seq_pool[k] - 32'($urandom_range(2));
                default: seq = seq_pool[k] + 32'($urandom_range(3));
            endcase
            seq_pool[k] = seq + 1;
            if ($urandom_range(9) == 0)
                send_frame(op, $urandom, 16'($urandom), seq, 4'($urandom));
            else
                send_frame(op, call_pool[k], ($urandom_range(3) == 0) ? VPN_ANY : 16'(k),
                           seq, 4'($urandom_range(3)));
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 8; i++) begin
            call_pool[i] = $urandom;
            seq_pool[i] = $urandom;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation, reboot sequence, stale frame
        send_frame(OP_BEACON, 32'h0, 16'h0, 32'h0, 4'h0);
        send_frame(OP_BEACON, 32'hFFFF_FFFF, 16'hFFFF, SEQ_ALL_ONES, 4'hF);
        send_frame(OP_BEACON, 32'h0, VPN_ANY, 32'd10, 4'h1);
        send_frame(OP_BEACON, 32'h0, 16'h0, 32'd10, 4'h0);
        send_frame(OP_DATA, 32'h0, 16'h0, 32'd20, 4'h0);
        send_frame(OP_DATA, 32'h0, 16'h0, 32'd5, 4'h0);
        send_frame(OP_DATA, 32'h0, 16'h0, SEQ_ALL_ONES, 4'h0);
        send_frame(OP_DATA, 32'h0, 16'h0, 32'd0, 4'h0);
        send_frame(OP_DATA, 32'h1234_5678, 16'h00AA, 32'h8000_0000, 4'h8);
        send_frame(OP_TICK, 32'h0, 16'h0, 32'h0, 4'h0);
        send_frame(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, SEQ_ALL_ONES, 4'hF);
        drain();

        // aging at the shortest thresholds
        write_reg(REG_RSSI_OFFSET, 17'd0);
        write_reg(REG_LOST_AFTER, 17'd1);
        write_reg(REG_DROP_AFTER, 17'd1);
        repeat (4) send_frame(OP_TICK, '0, '0, '0, '0);
        send_frame(OP_DATA, 32'hFFFF_FFFF, 16'hFFFF, 32'd3, 4'h0);
        drain();

        // fill the table
        write_reg(REG_RSSI_OFFSET, 17'd255);
        write_reg(REG_LOST_AFTER, 17'd86399);
        write_reg(REG_DROP_AFTER, 17'd86399);
        for (int i = 0; i < ENTRIES + 4; i++)
            send_frame(OP_BEACON, 32'h5000_0000 + i, 16'(i), 32'(i), 4'(i));
        drain();

        send_idle_pct = 20;
        recv_idle_pct = 64;
        random_phase(450);
        drain();

        // the table is full by now; use moderate aging to keep lookups alive
        write_reg(REG_RSSI_OFFSET, 17'd161);
        write_reg(REG_LOST_AFTER, 17'd3);
        write_reg(REG_DROP_AFTER, 17'd6);
        send_idle_pct = 64;
        recv_idle_pct = 20;
        random_phase(450);
        drain();

        write_reg(REG_LOST_AFTER, 17'd1800);
        write_reg(REG_DROP_AFTER, 17'd3600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(450);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
